// ----- sv/access_heatmap_binner_unit_macros.svh -----
// Assertion helpers for the heat-map binner checks.
`ifndef ACCESS_HEATMAP_BINNER_UNIT_MACROS_SVH
`define ACCESS_HEATMAP_BINNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AHM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heat-map binner check failed");

// Next-cycle implication, disabled during reset.
`define AHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heat-map binner check failed");

`endif

// ----- sv/ahm_pkg.sv -----
`timescale 1ns / 1ps

package ahm_pkg;

    localparam int ADDR_BITS     = 48;
    localparam int CMD_BITS      = 3;
    localparam int IDX_BITS      = 13;
    localparam int LEVEL_BITS    = 8;
    localparam int BIN_COUNT     = 8192;
    localparam int BIN_BITS      = $clog2(BIN_COUNT);
    localparam int GRANULE_SHIFT = 12;
    localparam int COUNT_BITS    = 32;
    localparam int CHANNELS      = 3;
    localparam int WIN_BITS      = GRANULE_SHIFT + BIN_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = 8'd255;
    localparam logic [ADDR_BITS-1:0]  BASE_RESET = 48'd3238002688;

    localparam logic [CMD_BITS-1:0] CMD_FETCH   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOAD    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_STORE   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_READOUT = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_END_ROW = 3'd4;

    localparam logic [1:0] CH_FETCH = 2'd0;
    localparam logic [1:0] CH_STORE = 2'd2;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CHANNELS-1:0][COUNT_BITS-1:0] row_t;

    typedef struct packed {
        logic   start;
        count_t count;
        count_t peak;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [LEVEL_BITS-1:0] level;
    } div_rsp_t;

endpackage

// ----- sv/ahm_count_ram.sv -----
`timescale 1ns / 1ps

module ahm_count_ram
(
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [ahm_pkg::BIN_BITS-1:0] wr_addr,
    input  ahm_pkg::row_t                wr_data,
    input  logic                         rd_en,
    input  logic [ahm_pkg::BIN_BITS-1:0] rd_addr,
    output ahm_pkg::row_t                rd_data
);

    ahm_pkg::row_t mem [ahm_pkg::BIN_COUNT];
    ahm_pkg::row_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ahm_divider.sv -----
`timescale 1ns / 1ps

// level = min(255, floor(count * 255 / peak)), or 0 when peak is zero; one quotient bit a cycle
module ahm_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  ahm_pkg::div_req_t req,
    output ahm_pkg::div_rsp_t rsp
);

    localparam int PW = ahm_pkg::COUNT_BITS + ahm_pkg::LEVEL_BITS;

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [2:0]                          step_reg, step_next;
    ahm_pkg::count_t                     rem_reg, rem_next;
    ahm_pkg::count_t                     div_reg, div_next;
    logic [ahm_pkg::LEVEL_BITS-1:0]      low_reg, low_next;
    logic [ahm_pkg::LEVEL_BITS-1:0]      q_reg, q_next;
    logic [PW-1:0]                       prod;
    logic [ahm_pkg::COUNT_BITS:0]        trial;
    logic [ahm_pkg::COUNT_BITS:0]        diff;

    assign prod  = {req.count, {ahm_pkg::LEVEL_BITS{1'b0}}}
                 - {{ahm_pkg::LEVEL_BITS{1'b0}}, req.count};
    assign trial = {rem_reg, low_reg[ahm_pkg::LEVEL_BITS-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            div_next = req.peak;
            if (req.peak == '0)
            begin
                q_next    = '0;
                done_next = 1'b1;
            end
            else if (req.count >= req.peak)
            begin
                q_next    = ahm_pkg::FULL_LEVEL;
                done_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = '0;
                rem_next  = prod[PW-1:ahm_pkg::LEVEL_BITS];
                low_next  = prod[ahm_pkg::LEVEL_BITS-1:0];
                q_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!diff[ahm_pkg::COUNT_BITS])
            begin
                rem_next = diff[ahm_pkg::COUNT_BITS-1:0];
                q_next   = {q_reg[ahm_pkg::LEVEL_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ahm_pkg::COUNT_BITS-1:0];
                q_next   = {q_reg[ahm_pkg::LEVEL_BITS-2:0], 1'b0};
            end
            low_next  = {low_reg[ahm_pkg::LEVEL_BITS-2:0], 1'b0};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.level = q_reg;

endmodule

// ----- sv/access_heatmap_binner_unit.sv -----
`timescale 1ns / 1ps

// Memory-access heat-map binner.
// Input words (cmd, address, bin_index) are taken on in_valid with in_stall low;
// result words (in_window and three levels) leave on out_valid with out_stall low.
// Every input word yields exactly one result word. cfg_valid/cfg_data write the
// window base; cfg_ready is always high, writes are expected only when idle.
// One word at a time: in_stall stays high from acceptance until the result is
// loaded into the output register.
// Steps: a counted mark goes through check, read, mark and emit; misses, end-row
// and unused commands go from check to emit; a readout goes through check, read,
// divide and emit; the shared divider yields one quotient bit per cycle and
// serves the three colour channels in turn, skipping the bit loop when the
// peak is zero or not above the count.
// After reset the counter memory is swept to zero, one bin per cycle, over all
// 8192 bins; in_stall is high during the sweep.
// A stalled result is held in the output register; a finished word waits until
// that register is free, and no further input is taken meanwhile.
module access_heatmap_binner_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ahm_pkg::ADDR_BITS-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [ahm_pkg::CMD_BITS-1:0]         cmd,
    input  logic [ahm_pkg::ADDR_BITS-1:0]        address,
    input  logic [ahm_pkg::IDX_BITS-1:0]         bin_index,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 in_window,
    output logic [ahm_pkg::LEVEL_BITS-1:0]       red_level,
    output logic [ahm_pkg::LEVEL_BITS-1:0]       green_level,
    output logic [ahm_pkg::LEVEL_BITS-1:0]       blue_level
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_MARK  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    typedef logic [ahm_pkg::CHANNELS-1:0][ahm_pkg::LEVEL_BITS-1:0] levels_t;

    logic [2:0]                           state_reg, state_next;
    logic [ahm_pkg::BIN_BITS-1:0]         clr_addr_reg, clr_addr_next;
    logic [ahm_pkg::ADDR_BITS-1:0]        window_base_reg;
    logic [ahm_pkg::CMD_BITS-1:0]         cmd_reg, cmd_next;
    logic [ahm_pkg::ADDR_BITS-1:0]        off_reg, off_next;
    logic [ahm_pkg::IDX_BITS-1:0]         idx_reg, idx_next;
    logic [ahm_pkg::BIN_BITS-1:0]         bin_reg, bin_next;
    logic [1:0]                           ch_reg, ch_next;
    logic                                 div_run_reg, div_run_next;
    ahm_pkg::row_t                        peak_reg, peak_next;
    logic                                 res_win_reg, res_win_next;
    levels_t                              res_lvl_reg, res_lvl_next;
    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_win_reg;
    levels_t                              out_lvl_reg;
    logic                                 emit;

    logic                                 wr_en, rd_en;
    logic [ahm_pkg::BIN_BITS-1:0]         wr_addr;
    ahm_pkg::row_t                        wr_data, rd_data;
    ahm_pkg::count_t                      bumped;
    ahm_pkg::div_req_t                    div_req;
    ahm_pkg::div_rsp_t                    div_rsp;

    ahm_count_ram u_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (bin_reg),
        .rd_data (rd_data)
    );

    ahm_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign bumped    = (rd_data[ch_reg] == ahm_pkg::COUNT_MAX) ? rd_data[ch_reg]
                                                                : rd_data[ch_reg] + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cmd_next       = cmd_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        bin_next       = bin_reg;
        ch_next        = ch_reg;
        div_run_next   = div_run_reg;
        peak_next      = peak_reg;
        res_win_next   = res_win_reg;
        res_lvl_next   = res_lvl_reg;
        wr_en          = 1'b0;
        wr_addr        = bin_reg;
        wr_data        = '0;
        rd_en          = 1'b0;
        div_req.start  = 1'b0;
        div_req.count  = rd_data[ch_reg];
        div_req.peak   = peak_reg[ch_reg];
        emit           = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ahm_pkg::BIN_BITS'(ahm_pkg::BIN_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    off_next   = address - window_base_reg;
                    idx_next   = bin_index;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_win_next = 1'b0;
                res_lvl_next = '0;
                state_next   = ST_EMIT;
                unique case (cmd_reg)
                    ahm_pkg::CMD_FETCH, ahm_pkg::CMD_LOAD, ahm_pkg::CMD_STORE:
                    begin
                        if (off_reg[ahm_pkg::ADDR_BITS-1:ahm_pkg::WIN_BITS] == '0)
                        begin
                            bin_next   = off_reg[ahm_pkg::GRANULE_SHIFT +: ahm_pkg::BIN_BITS];
                            ch_next    = cmd_reg[1:0];
                            state_next = ST_READ;
                        end
                    end
                    ahm_pkg::CMD_READOUT:
                    begin
                        if (32'(idx_reg) < ahm_pkg::BIN_COUNT)
                        begin
                            bin_next   = idx_reg[ahm_pkg::BIN_BITS-1:0];
                            ch_next    = ahm_pkg::CH_FETCH;
                            state_next = ST_READ;
                        end
                    end
                    ahm_pkg::CMD_END_ROW:
                    begin
                        peak_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_READ:
            begin
                rd_en        = 1'b1;
                div_run_next = 1'b0;
                state_next   = (cmd_reg == ahm_pkg::CMD_READOUT) ? ST_DIV : ST_MARK;
            end
            ST_MARK:
            begin
                wr_en           = 1'b1;
                wr_data         = rd_data;
                wr_data[ch_reg] = bumped;
                if (bumped > peak_reg[ch_reg])
                begin
                    peak_next[ch_reg] = bumped;
                end
                res_win_next = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_DIV:
            begin
                if (!div_run_reg)
                begin
                    div_req.start = 1'b1;
                    div_run_next  = 1'b1;
                    wr_en         = (ch_reg == ahm_pkg::CH_FETCH);
                end
                else if (div_rsp.done)
                begin
                    res_lvl_next[ch_reg] = div_rsp.level;
                    div_run_next         = 1'b0;
                    if (ch_reg == ahm_pkg::CH_STORE)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            window_base_reg <= ahm_pkg::BASE_RESET;
            peak_reg        <= '0;
            div_run_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            peak_reg      <= peak_next;
            div_run_reg   <= div_run_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_base_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        off_reg     <= off_next;
        idx_reg     <= idx_next;
        bin_reg     <= bin_next;
        ch_reg      <= ch_next;
        res_win_reg <= res_win_next;
        res_lvl_reg <= res_lvl_next;
        if (emit)
        begin
            out_win_reg <= res_win_reg;
            out_lvl_reg <= res_lvl_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign in_window   = out_win_reg;
    assign red_level   = out_lvl_reg[0];
    assign green_level = out_lvl_reg[1];
    assign blue_level  = out_lvl_reg[2];

endmodule

// ----- sv/ahm_checker.sv -----
`timescale 1ns / 1ps

`include "access_heatmap_binner_unit_macros.svh"

module ahm_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           in_window,
    input logic [ahm_pkg::LEVEL_BITS-1:0] red_level,
    input logic [ahm_pkg::LEVEL_BITS-1:0] green_level,
    input logic [ahm_pkg::LEVEL_BITS-1:0] blue_level
);

    logic [3*ahm_pkg::LEVEL_BITS-1:0] pixel;

    assign pixel = {red_level, green_level, blue_level};

    // held result
    `AHM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({in_window, pixel}))

    // a counted mark carries no pixel
    `AHM_ASSERT_SAME(a_mark_no_level, out_valid && in_window, pixel == '0)

    // one word at a time
    `AHM_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

    // a new result only comes out of a busy block
    `AHM_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule

bind access_heatmap_binner_unit ahm_checker u_ahm_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .in_window   (in_window),
    .red_level   (red_level),
    .green_level (green_level),
    .blue_level  (blue_level)
);
